// File: rtl/core/source_token_scanner_macros.svh
// assertion macros used by the source token scanner checker
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// File: rtl/core/sts_pkg.sv
// Shared types and constants of the source token scanner
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

    localparam int STS_POS_BITS       = 16;
    localparam int STS_KEYWORD_PREFIX = 6;
    localparam int MAX_RESULTS        = 3;
    localparam int RES_CNT_W          = 2;

    typedef logic [5:0] token_type_t;
    typedef logic [1:0] error_kind_t;

    localparam token_type_t TT_IDENT    = 6'd0;
    localparam token_type_t TT_STRING   = 6'd1;
    localparam token_type_t TT_NUMBER   = 6'd2;
    localparam token_type_t TT_KW_FIRST = 6'd3;
    localparam token_type_t TT_PLUS     = 6'd19;
    localparam token_type_t TT_MINUS    = 6'd20;
    localparam token_type_t TT_STAR     = 6'd21;
    localparam token_type_t TT_SLASH    = 6'd22;
    localparam token_type_t TT_LESS     = 6'd23;
    localparam token_type_t TT_COMMA    = 6'd31;
    localparam token_type_t TT_SEMI     = 6'd32;
    localparam token_type_t TT_DOT      = 6'd33;
    localparam token_type_t TT_LBRACE   = 6'd34;
    localparam token_type_t TT_RBRACE   = 6'd35;
    localparam token_type_t TT_LPAREN   = 6'd36;
    localparam token_type_t TT_RPAREN   = 6'd37;
    localparam token_type_t TT_ERROR    = 6'd38;
    localparam token_type_t TT_EOF      = 6'd39;

    localparam error_kind_t ERR_NONE         = 2'd0;
    localparam error_kind_t ERR_UNTERMINATED = 2'd1;
    localparam error_kind_t ERR_UNKNOWN_CHAR = 2'd2;

    typedef struct packed {
        token_type_t token_type;
        error_kind_t error_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last;
    } token_t;

endpackage

`default_nettype wire

// File: rtl/core/sts_byte_if.sv
// Source byte channel of the source token scanner
`timescale 1ns / 1ps
`default_nettype none

interface sts_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);

endinterface

`default_nettype wire

// File: rtl/core/sts_token_if.sv
// Token result channel of the source token scanner
`timescale 1ns / 1ps
`default_nettype none

interface sts_token_if import sts_pkg::*; ();

    logic        valid;
    logic        ready;
    token_type_t token_type;
    error_kind_t error_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last;

    modport source (
        output valid, output token_type, output error_kind, output start_offset,
        output token_length, output line_number, output last, input ready
    );
    modport sink (
        input valid, input token_type, input error_kind, input start_offset,
        input token_length, input line_number, input last, output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/sts_kw_match.sv
// Keyword lookup on the stored identifier prefix
`timescale 1ns / 1ps
`default_nettype none

module sts_kw_match import sts_pkg::*; #(
    parameter int POS_BITS       = STS_POS_BITS,
    parameter int KEYWORD_PREFIX = STS_KEYWORD_PREFIX
) (
    input  logic [KEYWORD_PREFIX-1:0][7:0] prefix,
    input  logic [POS_BITS-1:0]            length,
    output token_type_t                    word_type
);

    localparam int KW_COUNT   = 16;
    localparam int KW_MAX_LEN = 6;

    // text is left aligned, padding never compared
    localparam logic [0:KW_MAX_LEN-1][7:0] KW_TEXT [KW_COUNT] = '{
        "var   ", "print ", "if    ", "else  ",
        "while ", "false ", "func  ", "for   ",
        "class ", "true  ", "this  ", "super ",
        "nil   ", "return", "and   ", "or    "
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd5, 4'd4, 4'd3,
        4'd5, 4'd4, 4'd4, 4'd5, 4'd3, 4'd6, 4'd3, 4'd2
    };

    always_comb
    begin
        logic same;
        word_type = TT_IDENT;
        // lowest entry wins
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            same = (length == POS_BITS'(KW_LEN[k])) && (int'(KW_LEN[k]) <= KEYWORD_PREFIX);
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if ((i < int'(KW_LEN[k])) && (prefix[i] != KW_TEXT[k][i]))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                word_type = TT_KW_FIRST + 6'(k);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sts_result_fifo.sv
// Result queue that spreads up to three tokens per byte over the output channel
`timescale 1ns / 1ps
`default_nettype none

module sts_result_fifo import sts_pkg::*; (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [RES_CNT_W-1:0]              push_count,
    input  token_t [MAX_RESULTS-1:0]          push_items,
    output logic                              room,
    sts_token_if.source                       tokens
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [RES_CNT_W-1:0] n_push;
    logic               pop;
    token_t             head;

    assign n_push = push ? push_count : '0;
    assign pop    = (count_reg != '0) && tokens.ready;
    assign room   = count_reg <= CNT_W'(DEPTH - MAX_RESULTS);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if (RES_CNT_W'(j) < n_push)
            begin
                slots_reg[wr_ptr_reg + PTR_W'(j)] <= push_items[j];
            end
        end
    end

    assign head = slots_reg[rd_ptr_reg];

    assign tokens.valid        = count_reg != '0;
    assign tokens.token_type   = head.token_type;
    assign tokens.error_kind   = head.error_kind;
    assign tokens.start_offset = head.start_offset;
    assign tokens.token_length = head.token_length;
    assign tokens.line_number  = head.line_number;
    assign tokens.last         = head.last;

endmodule

`default_nettype wire

// File: rtl/core/sts_scan_core.sv
// Scanner state and per-byte token decision
`timescale 1ns / 1ps
`default_nettype none

module sts_scan_core import sts_pkg::*; #(
    parameter int POS_BITS       = STS_POS_BITS,
    parameter int KEYWORD_PREFIX = STS_KEYWORD_PREFIX
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               ch,
    output token_t [MAX_RESULTS-1:0] results,
    output logic [RES_CNT_W-1:0]     result_count
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_NUMDOT,
        M_FRACTION,
        M_STRING,
        M_OPER,
        M_SLASH,
        M_COMMENT
    } mode_t;

    mode_t                          mode_reg;
    mode_t                          mode_next;
    logic [1:0]                     pend_reg;
    logic [1:0]                     pend_next;
    logic [POS_BITS-1:0]            start_reg;
    logic [POS_BITS-1:0]            start_next;
    logic [POS_BITS-1:0]            len_reg;
    logic [POS_BITS-1:0]            len_next;
    logic [POS_BITS-1:0]            pos_reg;
    logic [POS_BITS-1:0]            pos_next;
    logic [POS_BITS-1:0]            line_reg;
    logic [POS_BITS-1:0]            line_next;
    logic [KEYWORD_PREFIX-1:0][7:0] pfx_reg;

    logic                is_letter;
    logic                is_digit;
    token_type_t         word_type;
    logic                used;
    logic                line_inc;
    logic                at_eof;
    logic                opening;
    mode_t               open_mode;
    logic                single_v;
    token_type_t         single_type;
    logic                pfx_we;
    logic [POS_BITS-1:0] pfx_idx;
    logic                a_v;
    logic                b_v;
    logic                f_v;
    token_t              a_tok;
    token_t              b_tok;
    token_t              f_tok;

    function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                    input logic [POS_BITS-1:0] b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
    endfunction

    function automatic token_t make_tok(input token_type_t t, input error_kind_t e,
                                        input logic [POS_BITS-1:0] st,
                                        input logic [POS_BITS-1:0] ln,
                                        input logic [POS_BITS-1:0] lc);
        token_t r;
        r.token_type   = t;
        r.error_kind   = e;
        r.start_offset = clamp16(st);
        r.token_length = clamp16(ln);
        r.line_number  = clamp16(lc);
        r.last         = 1'b0;
        return r;
    endfunction

    assign is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A))
                     || (ch == CH_UNDER);
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);

    sts_kw_match #(
        .POS_BITS       (POS_BITS),
        .KEYWORD_PREFIX (KEYWORD_PREFIX)
    ) u_kw_match (
        .prefix    (pfx_reg),
        .length    (len_reg),
        .word_type (word_type)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        used        = 1'b0;
        line_inc    = 1'b0;
        at_eof      = 1'b0;
        opening     = 1'b0;
        open_mode   = M_IDLE;
        single_v    = 1'b0;
        single_type = TT_PLUS;
        pfx_we      = 1'b0;
        pfx_idx     = len_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        f_v         = 1'b0;
        a_tok       = '0;
        b_tok       = '0;
        f_tok       = '0;

        // pending token
        case (mode_reg)
            M_IDENT:
            begin
                if (is_letter || is_digit)
                begin
                    used     = 1'b1;
                    pfx_we   = len_reg < POS_BITS'(KEYWORD_PREFIX);
                    len_next = sat_inc(len_reg);
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(word_type, ERR_NONE, start_reg, len_reg, line_reg);
                    mode_next = M_IDLE;
                end
            end
            M_NUMBER:
            begin
                if (is_digit)
                begin
                    used     = 1'b1;
                    len_next = sat_inc(len_reg);
                end
                else if (ch == CH_DOT)
                begin
                    used      = 1'b1;
                    mode_next = M_NUMDOT;
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(TT_NUMBER, ERR_NONE, start_reg, len_reg, line_reg);
                    mode_next = M_IDLE;
                end
            end
            M_NUMDOT:
            begin
                if (is_digit)
                begin
                    used      = 1'b1;
                    len_next  = sat_add(len_reg, POS_BITS'(2));
                    mode_next = M_FRACTION;
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(TT_NUMBER, ERR_NONE, start_reg, len_reg, line_reg);
                    b_v       = 1'b1;
                    b_tok     = make_tok(TT_DOT, ERR_NONE, sat_add(start_reg, len_reg),
                                         POS_BITS'(1), line_reg);
                    mode_next = M_IDLE;
                end
            end
            M_FRACTION:
            begin
                if (is_digit)
                begin
                    used     = 1'b1;
                    len_next = sat_inc(len_reg);
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(TT_NUMBER, ERR_NONE, start_reg, len_reg, line_reg);
                    mode_next = M_IDLE;
                end
            end
            M_STRING:
            begin
                if (ch == CH_NUL)
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(TT_ERROR, ERR_UNTERMINATED, start_reg, len_reg,
                                         line_reg);
                    mode_next = M_IDLE;
                end
                else
                begin
                    used     = 1'b1;
                    len_next = sat_inc(len_reg);
                    line_inc = ch == CH_LF;
                    if (ch == CH_QUOTE)
                    begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(TT_STRING, ERR_NONE, start_reg, sat_inc(len_reg),
                                             line_reg);
                        mode_next = M_IDLE;
                    end
                end
            end
            M_OPER:
            begin
                a_v = 1'b1;
                if (ch == CH_EQUAL)
                begin
                    used  = 1'b1;
                    a_tok = make_tok(TT_LESS + {3'b000, pend_reg, 1'b1}, ERR_NONE, start_reg,
                                     POS_BITS'(2), line_reg);
                end
                else
                begin
                    a_tok = make_tok(TT_LESS + {3'b000, pend_reg, 1'b0}, ERR_NONE, start_reg,
                                     POS_BITS'(1), line_reg);
                end
                mode_next = M_IDLE;
            end
            M_SLASH:
            begin
                if (ch == CH_SLASH)
                begin
                    used      = 1'b1;
                    mode_next = M_COMMENT;
                end
                else
                begin
                    a_v       = 1'b1;
                    a_tok     = make_tok(TT_SLASH, ERR_NONE, start_reg, POS_BITS'(1), line_reg);
                    mode_next = M_IDLE;
                end
            end
            M_COMMENT:
            begin
                if ((ch == CH_LF) || (ch == CH_NUL))
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    used = 1'b1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        // byte not taken by the pending token
        if (!used)
        begin
            if (ch == CH_NUL)
            begin
                at_eof    = 1'b1;
                f_v       = 1'b1;
                f_tok     = make_tok(TT_EOF, ERR_NONE, pos_reg, '0, line_reg);
                mode_next = M_IDLE;
            end
            else
            begin
                case (ch)
                    CH_SPACE, CH_TAB, CH_CR:
                    begin
                        line_inc = 1'b0;
                    end
                    CH_LF:
                    begin
                        line_inc = 1'b1;
                    end
                    CH_QUOTE:
                    begin
                        opening   = 1'b1;
                        open_mode = M_STRING;
                    end
                    CH_SLASH:
                    begin
                        opening   = 1'b1;
                        open_mode = M_SLASH;
                    end
                    CH_LESS:
                    begin
                        opening   = 1'b1;
                        open_mode = M_OPER;
                        pend_next = 2'd0;
                    end
                    CH_GREATER:
                    begin
                        opening   = 1'b1;
                        open_mode = M_OPER;
                        pend_next = 2'd1;
                    end
                    CH_EQUAL:
                    begin
                        opening   = 1'b1;
                        open_mode = M_OPER;
                        pend_next = 2'd2;
                    end
                    CH_BANG:
                    begin
                        opening   = 1'b1;
                        open_mode = M_OPER;
                        pend_next = 2'd3;
                    end
                    CH_PLUS:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_PLUS;
                    end
                    CH_MINUS:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_MINUS;
                    end
                    CH_STAR:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_STAR;
                    end
                    CH_COMMA:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_COMMA;
                    end
                    CH_SEMI:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_SEMI;
                    end
                    CH_DOT:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_DOT;
                    end
                    CH_LBRACE:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_LBRACE;
                    end
                    CH_RBRACE:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_RBRACE;
                    end
                    CH_LPAREN:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_LPAREN;
                    end
                    CH_RPAREN:
                    begin
                        single_v    = 1'b1;
                        single_type = TT_RPAREN;
                    end
                    default:
                    begin
                        if (is_letter)
                        begin
                            opening   = 1'b1;
                            open_mode = M_IDENT;
                            pfx_we    = 1'b1;
                            pfx_idx   = '0;
                        end
                        else if (is_digit)
                        begin
                            opening   = 1'b1;
                            open_mode = M_NUMBER;
                        end
                        else
                        begin
                            f_v   = 1'b1;
                            f_tok = make_tok(TT_ERROR, ERR_UNKNOWN_CHAR, pos_reg,
                                             POS_BITS'(1), line_reg);
                        end
                    end
                endcase

                if (single_v)
                begin
                    f_v   = 1'b1;
                    f_tok = make_tok(single_type, ERR_NONE, pos_reg, POS_BITS'(1), line_reg);
                end
                if (opening)
                begin
                    mode_next  = open_mode;
                    start_next = pos_reg;
                    len_next   = POS_BITS'(1);
                end
            end
        end

        if (at_eof)
        begin
            pos_next  = '0;
            line_next = POS_BITS'(1);
        end
        else
        begin
            pos_next  = sat_inc(pos_reg);
            line_next = line_inc ? sat_inc(line_reg) : line_reg;
        end
    end

    // pack the tokens in emission order, mark the final one
    always_comb
    begin
        results = '0;
        if (a_v)
        begin
            results[0] = a_tok;
            if (b_v)
            begin
                results[1] = b_tok;
                results[2] = f_tok;
            end
            else
            begin
                results[1] = f_tok;
            end
        end
        else
        begin
            results[0] = f_tok;
        end
        result_count = RES_CNT_W'(a_v) + RES_CNT_W'(b_v) + RES_CNT_W'(f_v);
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            results[j].last = RES_CNT_W'(j) == (result_count - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pend_reg  <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            line_reg  <= POS_BITS'(1);
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && pfx_we)
        begin
            for (int j = 0; j < KEYWORD_PREFIX; j++)
            begin
                if (pfx_idx == POS_BITS'(j))
                begin
                    pfx_reg[j] <= ch;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/source_token_scanner.sv
// Top level of the source token scanner
//
// chars carries one source byte per request (ch), a byte of 0 ends the source.
// tokens carries one token per request: type, error kind, offset, length,
// line and a last flag on the final token caused by a byte.
// The tokens of an accepted byte are registered in the result queue, and
// tokens shows the head of that queue.
// One byte is taken every cycle while each byte yields at most one token and
// tokens is drained. A byte that closes a pending token and also yields one of
// its own (an operator, an unknown byte or the end of source), or a non-digit
// after a number and its dot, yields two or three tokens that leave in order
// through a four-entry result queue; chars.ready is low while fewer than three
// entries are free.
// When tokens stalls, up to four tokens wait in the queue and chars.ready
// drops; no byte is taken until room frees up.
// Reset empties the queue and restarts scanning at offset 0, line 1.
`timescale 1ns / 1ps
`default_nettype none

module source_token_scanner import sts_pkg::*; #(
    parameter int POS_BITS       = STS_POS_BITS,
    parameter int KEYWORD_PREFIX = STS_KEYWORD_PREFIX
) (
    input  logic        clk,
    input  logic        rst_n,
    sts_byte_if.sink    chars,
    sts_token_if.source tokens
);

    logic                     room;
    logic                     step;
    token_t [MAX_RESULTS-1:0] results;
    logic [RES_CNT_W-1:0]     result_count;

    assign chars.ready = room;
    assign step        = chars.valid && room;

    sts_scan_core #(
        .POS_BITS       (POS_BITS),
        .KEYWORD_PREFIX (KEYWORD_PREFIX)
    ) u_scan_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ch           (chars.ch),
        .results      (results),
        .result_count (result_count)
    );

    sts_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_count (result_count),
        .push_items (results),
        .room       (room),
        .tokens     (tokens)
    );

endmodule

`default_nettype wire

// File: rtl/core/sts_checker.sv
// Port-level assertions of the source token scanner and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "source_token_scanner_macros.svh"

module sts_checker import sts_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input token_type_t token_type,
    input error_kind_t error_kind,
    input logic        last
);

    `STS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "token dropped while stalled")
    `STS_ASSERT_IMP(a_err_kind, clk, rst_n, out_valid, (token_type == TT_ERROR) == (error_kind != ERR_NONE), "error kind does not match token type")
    `STS_ASSERT_IMP(a_eof_last, clk, rst_n, out_valid && (token_type == TT_EOF), last, "eof token is not last")
    `STS_ASSERT_IMP(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready), "token without an accepted byte")

endmodule

bind source_token_scanner sts_checker u_sts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .token_type (tokens.token_type),
    .error_kind (tokens.error_kind),
    .last       (tokens.last)
);

`default_nettype wire
